FILE: src/intc32_pkg.sv
package intc32_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned LINE_IDX_W = 5;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned OFS_W = 3;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  localparam logic [OFS_W-1:0] OFS_SOURCE = 3'd0;
  localparam logic [OFS_W-1:0] OFS_MASK = 3'd1;
  localparam logic [OFS_W-1:0] OFS_CLEAR = 3'd2;
  localparam logic [OFS_W-1:0] OFS_MODE = 3'd3;
  localparam logic [OFS_W-1:0] OFS_POLARITY = 3'd4;
  localparam logic [OFS_W-1:0] OFS_STATUS = 3'd5;

  typedef struct packed {
    logic             tick;
    logic             wr;
    logic [OFS_W-1:0] ofs;
  } bank_req_t;

  // Packed so that the first output field lands in the lowest bits.
  typedef struct packed {
    logic                  irq_line_valid;
    logic [LINE_IDX_W-1:0] lowest_irq_line;
    logic                  fiq_request;
    logic                  irq_request;
    logic [DATA_W-1:0]     read_value;
  } result_t;

endpackage

FILE: src/intc32_bank.sv
module intc32_bank #(
  parameter int unsigned NUM_LINES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  intc32_pkg::bank_req_t req_i,
  input  logic [NUM_LINES-1:0]  wdata_i,
  input  logic [NUM_LINES-1:0]  levels_i,
  input  logic [NUM_LINES-1:0]  prev_i,
  output logic [NUM_LINES-1:0]  rdata_o,
  output logic [NUM_LINES-1:0]  status_o
);
  import intc32_pkg::*;

  logic [NUM_LINES-1:0] enable_q, enable_d;
  logic [NUM_LINES-1:0] mode_q, mode_d;
  logic [NUM_LINES-1:0] pol_q, pol_d;
  logic [NUM_LINES-1:0] latch_q, latch_d;
  logic [NUM_LINES-1:0] prev_d;
  logic [NUM_LINES-1:0] edge_hit;
  logic [NUM_LINES-1:0] source_q;

  assign edge_hit = (~prev_i & levels_i & ~pol_q) | (prev_i & ~levels_i & pol_q);
  assign prev_d   = req_i.tick ? levels_i : prev_i;
  assign source_q = ((prev_i ^ pol_q) & ~mode_q) | latch_q;

  always_comb begin
    enable_d = enable_q;
    mode_d   = mode_q;
    pol_d    = pol_q;
    latch_d  = latch_q;
    if (req_i.tick) begin
      latch_d = latch_q | (edge_hit & mode_q);
    end else if (req_i.wr) begin
      unique case (req_i.ofs)
        OFS_MASK:     enable_d = wdata_i;
        OFS_CLEAR:    latch_d  = latch_q & ~wdata_i;
        OFS_MODE:     mode_d   = wdata_i;
        OFS_POLARITY: pol_d    = wdata_i;
        default:      ;
      endcase
    end
  end

  // Status as it stands once the current transfer has taken effect.
  assign status_o = (((prev_d ^ pol_d) & ~mode_d) | latch_d) & enable_d;

  always_comb begin
    unique case (req_i.ofs)
      OFS_SOURCE:   rdata_o = source_q;
      OFS_MASK:     rdata_o = enable_q;
      OFS_MODE:     rdata_o = mode_q;
      OFS_POLARITY: rdata_o = pol_q;
      OFS_STATUS:   rdata_o = source_q & enable_q;
      default:      rdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      mode_q   <= '0;
      pol_q    <= '0;
      latch_q  <= '0;
    end else begin
      enable_q <= enable_d;
      mode_q   <= mode_d;
      pol_q    <= pol_d;
      latch_q  <= latch_d;
    end
  end

  a_tick_keeps_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.tick |=> ((latch_q & $past(latch_q)) == $past(latch_q)))
    else $error("latched edge lost on a tick");

  a_clear_drops_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.wr && req_i.ofs == OFS_CLEAR) |=> ((latch_q & $past(wdata_i)) == '0))
    else $error("latch bit survived a clear write");

  a_other_write_keeps_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.wr && req_i.ofs != OFS_CLEAR) |=> $stable(latch_q))
    else $error("latch changed by a write to another register");

endmodule

FILE: src/intc32_merge.sv
module intc32_merge #(
  parameter int unsigned NUM_LINES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [intc32_pkg::DATA_W-1:0]    rd_data_i,
  input  logic [NUM_LINES-1:0]             irq_status_i,
  input  logic [NUM_LINES-1:0]             fiq_status_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output intc32_pkg::result_t              out_data_o
);
  import intc32_pkg::*;

  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    pop;

  always_comb begin
    res                 = '0;
    res.read_value      = rd_data_i;
    res.irq_request     = |irq_status_i;
    res.fiq_request     = |fiq_status_i;
    res.irq_line_valid  = |irq_status_i;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (irq_status_i[i]) begin
        res.lowest_irq_line = LINE_IDX_W'(i);
      end
    end
  end

  assign pop         = out_valid_q && out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_line_valid_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.irq_line_valid == out_q.irq_request))
    else $error("line valid disagrees with IRQ request");

  a_idle_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.irq_line_valid) |-> (out_q.lowest_irq_line == '0))
    else $error("line index nonzero with nothing pending");

endmodule

FILE: src/interrupt_controller_32_line.sv
// A result is registered in an output buffer before it appears on the master side.
// Throughput: one transfer per cycle while that buffer is not full; the two interrupt
// banks work in parallel lanes. Its two entries keep the slave side ready while one
// result waits. Reset is asynchronous and active low; it clears the bank registers and
// the sampled levels, masks all lines, selects level mode and active high, and empties
// the edge latches and the output buffer.
module interrupt_controller_32_line #(
  parameter int unsigned NUM_LINES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] reg_index, [35:4] write_value, [67:36] line_levels, [71:68] zero
  input  logic [71:0] s_axis_tdata_i,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] read_value, [32] irq_request, [33] fiq_request,
  // [38:34] lowest_irq_line, [39] irq_line_valid
  output logic [39:0] m_axis_tdata_o
);
  import intc32_pkg::*;

  logic                 accept;
  logic [CMD_W-1:0]     cmd;
  logic [IDX_W-1:0]     reg_index;
  logic [DATA_W-1:0]    write_value;
  logic [DATA_W-1:0]    line_levels;
  logic [NUM_LINES-1:0] wdata, levels;
  logic [NUM_LINES-1:0] prev_q;
  logic [NUM_LINES-1:0] irq_rd, fiq_rd, irq_st, fiq_st;
  logic [DATA_W-1:0]    rd_data;
  logic                 is_tick, is_read, is_write;
  bank_req_t            irq_req, fiq_req;
  result_t              result;

  assign accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd         = s_axis_tuser_i;
  assign reg_index   = s_axis_tdata_i[3:0];
  assign write_value = s_axis_tdata_i[35:4];
  assign line_levels = s_axis_tdata_i[67:36];
  assign wdata       = write_value[NUM_LINES-1:0];
  assign levels      = line_levels[NUM_LINES-1:0];

  assign is_tick  = accept && (cmd == CMD_TICK);
  assign is_read  = cmd == CMD_READ;
  assign is_write = accept && (cmd == CMD_WRITE);

  assign irq_req.tick = is_tick;
  assign irq_req.wr   = is_write && !reg_index[3];
  assign irq_req.ofs  = reg_index[2:0];
  assign fiq_req.tick = is_tick;
  assign fiq_req.wr   = is_write && reg_index[3];
  assign fiq_req.ofs  = reg_index[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (is_tick) begin
      prev_q <= levels;
    end
  end

  intc32_bank #(.NUM_LINES(NUM_LINES)) u_irq_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (irq_req),
    .wdata_i  (wdata),
    .levels_i (levels),
    .prev_i   (prev_q),
    .rdata_o  (irq_rd),
    .status_o (irq_st)
  );

  intc32_bank #(.NUM_LINES(NUM_LINES)) u_fiq_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (fiq_req),
    .wdata_i  (wdata),
    .levels_i (levels),
    .prev_i   (prev_q),
    .rdata_o  (fiq_rd),
    .status_o (fiq_st)
  );

  assign rd_data = !is_read ? '0
                 : reg_index[3] ? DATA_W'(fiq_rd) : DATA_W'(irq_rd);

  intc32_merge #(.NUM_LINES(NUM_LINES)) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rd_data_i    (rd_data),
    .irq_status_i (irq_st),
    .fiq_status_i (fiq_st),
    .in_ready_o   (s_axis_tready_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (result)
  );

  assign m_axis_tdata_o = result;

endmodule

FILE: tb/tb_interrupt_controller_32_line.sv
module tb_interrupt_controller_32_line;
  import intc32_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam logic [OFS_W-1:0] OFS_SPARE6 = 3'd6;
  localparam logic [OFS_W-1:0] OFS_SPARE7 = 3'd7;
  localparam logic IRQ_B = 1'b0;
  localparam logic FIQ_B = 1'b1;
  localparam int N_ITEMS = 1350;
  localparam int N_DIR = 27;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [IDX_W-1:0]      idx;
    logic [DATA_W-1:0]     wval;
    logic [DATA_W-1:0]     lvl;
    logic                  typed;
    logic [DATA_W-1:0]     w_rd;
    logic                  w_irq;
    logic                  w_fiq;
    logic [LINE_IDX_W-1:0] w_low;
    logic                  w_vld;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_axis_tvalid_o;
  logic        m_tready = 1'b0;
  logic [39:0] m_axis_tdata_o;

  interrupt_controller_32_line i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  // Fields: cmd, reg_index, write_value, line_levels, then an optional typed-in result
  // (read_value, irq_request, fiq_request, lowest_irq_line, irq_line_valid).
  stim_t dir_tab [N_DIR] = '{
    '{CMD_READ, {IRQ_B, OFS_MASK}, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_READ, {FIQ_B, OFS_MASK}, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_READ, {IRQ_B, OFS_SOURCE}, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_WRITE, {IRQ_B, OFS_MASK}, 32'hFFFFFFFF, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_TICK, {IRQ_B, OFS_SOURCE}, 32'h0, 32'h80000000, 1'b1, 32'h0, 1'b1, 1'b0, 5'd31, 1'b1},
    '{CMD_READ, {IRQ_B, OFS_STATUS}, 32'h0, 32'h0, 1'b1, 32'h80000000, 1'b1, 1'b0, 5'd31,
      1'b1},
    '{CMD_TICK, {IRQ_B, OFS_SOURCE}, 32'h0, 32'hFFFFFFFF, 1'b1, 32'h0, 1'b1, 1'b0, 5'd0, 1'b1},
    '{CMD_WRITE, {IRQ_B, OFS_POLARITY}, 32'hFFFFFFFF, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0, 5'd0,
      1'b0},
    '{CMD_READ, {IRQ_B, OFS_POLARITY}, 32'h0, 32'h0, 1'b1, 32'hFFFFFFFF, 1'b0, 1'b0, 5'd0,
      1'b0},
    '{CMD_WRITE, {IRQ_B, OFS_MODE}, 32'hFFFFFFFF, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_TICK, {IRQ_B, OFS_SOURCE}, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1, 1'b0, 5'd0, 1'b1},
    '{CMD_WRITE, {IRQ_B, OFS_CLEAR}, 32'hFFFFFFFE, 32'h0, 1'b1, 32'h0, 1'b1, 1'b0, 5'd0, 1'b1},
    '{CMD_READ, {IRQ_B, OFS_CLEAR}, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1, 1'b0, 5'd0, 1'b1},
    '{CMD_WRITE, {IRQ_B, OFS_SOURCE}, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_WRITE, {IRQ_B, OFS_STATUS}, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_WRITE, {IRQ_B, OFS_CLEAR}, 32'h1, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_WRITE, {IRQ_B, OFS_SPARE6}, 32'hFFFFFFFF, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_READ, {IRQ_B, OFS_SPARE7}, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_READ, {FIQ_B, OFS_SPARE6}, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_NONE, {IRQ_B, OFS_SOURCE}, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0,
      1'b0},
    '{CMD_WRITE, {FIQ_B, OFS_MASK}, 32'h1, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_WRITE, {FIQ_B, OFS_MODE}, 32'h1, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_TICK, {FIQ_B, OFS_SOURCE}, 32'h0, 32'h1, 1'b1, 32'h0, 1'b0, 1'b1, 5'd0, 1'b0},
    '{CMD_WRITE, {FIQ_B, OFS_MODE}, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_READ, {FIQ_B, OFS_SOURCE}, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_WRITE, {FIQ_B, OFS_CLEAR}, 32'hFFFFFFFF, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0},
    '{CMD_READ, {FIQ_B, OFS_STATUS}, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 5'd0, 1'b0}
  };

  stim_t       cmd_queue [$];
  result_t     pending_results [$];
  int unsigned n_mismatch = 0;
  logic [31:0] gen_levels = '0;

  // Bank 0 is IRQ, bank 1 is FIQ.
  logic [31:0] mask_r [2] = '{default: '0};
  logic [31:0] edge_r [2] = '{default: '0};
  logic [31:0] lowact_r [2] = '{default: '0};
  logic [31:0] latch_r [2] = '{default: '0};
  logic [31:0] levels_r = '0;

  function automatic logic [31:0] bank_source(int b);
    return ((levels_r ^ lowact_r[b]) & ~edge_r[b]) | latch_r[b];
  endfunction

  function automatic result_t irq_ctrl_step(stim_t it);
    result_t     r;
    logic [31:0] rise;
    logic [31:0] fall;
    logic [31:0] irq_st;
    logic [31:0] fiq_st;
    int          b;
    r = '0;
    b = int'(it.idx[3]);
    case (it.cmd)
      CMD_TICK: begin
        rise = ~levels_r & it.lvl;
        fall = levels_r & ~it.lvl;
        for (int k = 0; k < 2; k++) begin
          latch_r[k] |= ((rise & ~lowact_r[k]) | (fall & lowact_r[k])) & edge_r[k];
        end
        levels_r = it.lvl;
      end
      CMD_READ: begin
        case (it.idx[2:0])
          OFS_SOURCE: r.read_value = bank_source(b);
          OFS_MASK: r.read_value = mask_r[b];
          OFS_MODE: r.read_value = edge_r[b];
          OFS_POLARITY: r.read_value = lowact_r[b];
          OFS_STATUS: r.read_value = bank_source(b) & mask_r[b];
          default: r.read_value = '0;
        endcase
      end
      CMD_WRITE: begin
        case (it.idx[2:0])
          OFS_MASK: mask_r[b] = it.wval;
          OFS_CLEAR: latch_r[b] &= ~it.wval;
          OFS_MODE: edge_r[b] = it.wval;
          OFS_POLARITY: lowact_r[b] = it.wval;
          default: ;
        endcase
      end
      default: ;
    endcase
    irq_st = bank_source(0) & mask_r[0];
    fiq_st = bank_source(1) & mask_r[1];
    r.irq_request = |irq_st;
    r.fiq_request = |fiq_st;
    r.irq_line_valid = |irq_st;
    for (int k = 31; k >= 0; k--) begin
      if (irq_st[k]) r.lowest_irq_line = 5'(k);
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h1 << $urandom_range(0, 31);
      1: return $urandom & $urandom & $urandom;
      2: return 32'hFFFFFFFF;
      3: return 32'h0;
      4: return 32'hFFFFFFFF << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic [1:0] c, logic [3:0] i, logic [31:0] w, logic [31:0] l);
    stim_t s;
    s = '0;
    s.cmd = c;
    s.idx = i;
    s.wval = w;
    s.lvl = l;
    cmd_queue.push_back(s);
  endtask

  // Configure one bank, drive a few line changes, look at it, and maybe acknowledge.
  task automatic add_episode();
    logic             b;
    logic [OFS_W-1:0] ofs;
    b = 1'($urandom_range(0, 1));
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 2))
        0: ofs = OFS_MASK;
        1: ofs = OFS_MODE;
        default: ofs = OFS_POLARITY;
      endcase
      add_item(CMD_WRITE, {b, ofs}, rand_word(), $urandom);
    end
    repeat ($urandom_range(2, 8)) begin
      gen_levels ^= rand_word();
      add_item(CMD_TICK, 4'($urandom), $urandom, gen_levels);
    end
    repeat ($urandom_range(1, 2)) begin
      add_item(CMD_READ, {b, 3'($urandom_range(0, 5))}, $urandom, $urandom);
    end
    if ($urandom_range(0, 1) == 1) add_item(CMD_WRITE, {b, OFS_CLEAR}, rand_word(), $urandom);
  endtask

  always @(posedge clk_i) begin : drive_proc
    stim_t       cur;
    result_t     r;
    int unsigned burst_left;
    int unsigned gap_left;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        r = irq_ctrl_step(cur);
        if (cur.typed) r = {cur.w_vld, cur.w_low, cur.w_fiq, cur.w_irq, cur.w_rd};
        pending_results.push_back(r);
      end
      if (!s_tvalid || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          cur = cmd_queue.pop_front();
          s_tdata <= {4'b0, cur.lvl, cur.wval, cur.idx};
          s_tuser <= cur.cmd;
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off lets the output buffer fill so the input side must stall.
  int unsigned rx_cycles = 0;
  int unsigned rx_phase = 0;
  int unsigned rx_mode = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycles++;
      if (rx_cycles >= 700 && rx_cycles < 900) begin
        m_tready <= 1'b0;
      end else begin
        if (rx_phase == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_phase = $urandom_range(5, 60);
        end
        rx_phase--;
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_proc
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", m_axis_tdata_o);
        n_mismatch++;
      end else begin
        want = pending_results.pop_front();
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, got.read_value);
          n_mismatch++;
        end
        if (got.irq_request !== want.irq_request) begin
          $error("irq_request: expected %b, got %b", want.irq_request, got.irq_request);
          n_mismatch++;
        end
        if (got.fiq_request !== want.fiq_request) begin
          $error("fiq_request: expected %b, got %b", want.fiq_request, got.fiq_request);
          n_mismatch++;
        end
        if (got.lowest_irq_line !== want.lowest_irq_line) begin
          $error("lowest_irq_line: expected %0d, got %0d", want.lowest_irq_line,
                 got.lowest_irq_line);
          n_mismatch++;
        end
        if (got.irq_line_valid !== want.irq_line_valid) begin
          $error("irq_line_valid: expected %b, got %b", want.irq_line_valid,
                 got.irq_line_valid);
          n_mismatch++;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < N_DIR; k++) cmd_queue.push_back(dir_tab[k]);
    while (cmd_queue.size() < N_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        add_episode();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_item(2'($urandom_range(0, 3)), 4'($urandom), rand_word(), $urandom);
        end
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cmd_queue.size() != 0 || s_tvalid) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
